/* src/uv_sphere_vertex_generator_defines.svh */
// Assertion helpers for the sphere generator top level.
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, gated off while reset is asserted.
`define UVS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uv sphere generator: check failed");

// Next-cycle implication, gated off while reset is asserted.
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("uv sphere generator: check failed");

`endif

/* src/uvs_pkg.sv */
package uvs_pkg;

    // Field and datapath widths.
    localparam int CNT_W    = 11;
    localparam int IDX_W    = 11;
    localparam int RAD_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W    = 17;
    localparam int NORM_W   = 16;
    localparam int NUM_W    = 43;
    localparam int QUO_W    = 33;
    localparam int PHASE_W  = 32;
    localparam int CORDIC_W = 33;
    localparam int TRIG_W   = 32;

    localparam int POS_LIMIT  = 65535;
    localparam int NORM_LIMIT = 16384;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STACK_COUNT   = 2'd0,
        CFG_SECTOR_COUNT  = 2'd1,
        CFG_SPHERE_RADIUS = 2'd2
    } t_cfg_reg;

    // Arctangent of 2^-k in phase units, 2^32 per turn.
    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Gain-compensated start vector, Q2.30.
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 33'sd652032874;

    // Pipeline tag that travels beside the data.
    typedef struct packed {
        logic valid;
        logic err;
    } t_tag;

    // Classified work item handed from the front to the back.
    typedef struct packed {
        logic [NUM_W-1:0] lat_num;
        logic [NUM_W-1:0] lon_num;
        logic [CNT_W-1:0] ns;
        logic [CNT_W-1:0] nc;
        logic             err;
    } t_job;

    // Symmetric saturation.
    function automatic logic signed [63:0] clamp_sym(
        input logic signed [63:0] v,
        input logic signed [63:0] lim
    );
        logic signed [63:0] res;
        res = v;
        if (v > lim) begin
            res = lim;
        end else if (v < -lim) begin
            res = -lim;
        end
        return res;
    endfunction

endpackage

/* src/uvs_front.sv */
module uvs_front #(
    parameter int MAX_DIVISIONS = 1024
) (
    input  logic                     i_valid,
    input  logic [uvs_pkg::IDX_W-1:0] i_stack_index,
    input  logic [uvs_pkg::IDX_W-1:0] i_sector_index,
    input  logic [uvs_pkg::CNT_W-1:0] i_stack_count,
    input  logic [uvs_pkg::CNT_W-1:0] i_sector_count,
    output logic                     o_push,
    output uvs_pkg::t_job            o_job
);
    import uvs_pkg::*;

    logic [CNT_W-1:0] ns;
    logic [CNT_W-1:0] nc;

    // Effective counts: zero acts as one, large counts saturate.
    always_comb begin
        if (i_stack_count == '0) begin
            ns = CNT_W'(1);
        end else if (32'(i_stack_count) > 32'(MAX_DIVISIONS)) begin
            ns = CNT_W'(MAX_DIVISIONS);
        end else begin
            ns = i_stack_count;
        end
        if (i_sector_count == '0) begin
            nc = CNT_W'(1);
        end else if (32'(i_sector_count) > 32'(MAX_DIVISIONS)) begin
            nc = CNT_W'(MAX_DIVISIONS);
        end else begin
            nc = i_sector_count;
        end
    end

    // Build the rounded dividends and flag out-of-range indexes.
    always_comb begin
        o_push        = i_valid;
        o_job.lat_num = {1'b0, i_stack_index, 31'd0} + NUM_W'(ns >> 1);
        o_job.lon_num = {i_sector_index, 32'd0} + NUM_W'(nc >> 1);
        o_job.ns      = ns;
        o_job.nc      = nc;
        o_job.err     = (i_stack_index > ns) || (i_sector_index > nc);
    end

endmodule

/* src/uvs_fifo.sv */
module uvs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uvs_pkg::t_job i_data,
    input  logic          i_pop,
    output uvs_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    import uvs_pkg::*;

    t_job       r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // Pointer and occupancy control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_data[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

/* src/uvs_divider.sv */
module uvs_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  uvs_pkg::t_tag             i_tag,
    input  logic [uvs_pkg::NUM_W-1:0] i_num,
    input  logic [uvs_pkg::CNT_W-1:0] i_div,
    output uvs_pkg::t_tag             o_tag,
    output logic [uvs_pkg::QUO_W-1:0] o_quo
);
    import uvs_pkg::*;

    localparam int STEPS = QUO_W;

    // One quotient bit per stage; r_w shifts dividend bits out and quotient bits in.
    logic [CNT_W-1:0] r_rem [STEPS+1];
    logic [QUO_W-1:0] r_w   [STEPS+1];
    logic [CNT_W-1:0] r_div [STEPS+1];
    t_tag             r_tag [STEPS+1];

    // Load stage: the top dividend bits are already below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_num[NUM_W-1:QUO_W]};
            r_w[0]   <= i_num[QUO_W-1:0];
            r_div[0] <= i_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else if (i_en) begin
            r_tag[0] <= i_tag;
        end
    end

    // Restoring division steps.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [CNT_W:0] sh;
        logic [CNT_W:0] diff;
        logic           ge;

        assign sh   = {r_rem[k], r_w[k][QUO_W-1]};
        assign ge   = (sh >= {1'b0, r_div[k]});
        assign diff = sh - {1'b0, r_div[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? diff[CNT_W-1:0] : sh[CNT_W-1:0];
                r_w[k+1]   <= {r_w[k][QUO_W-2:0], ge};
                r_div[k+1] <= r_div[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1] <= '0;
            end else if (i_en) begin
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_tag = r_tag[STEPS];
    assign o_quo = r_w[STEPS];

endmodule

/* src/uvs_cordic.sv */
module uvs_cordic #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  uvs_pkg::t_tag               i_tag,
    input  logic [uvs_pkg::PHASE_W-1:0] i_phase,
    output uvs_pkg::t_tag               o_tag,
    output logic signed [uvs_pkg::TRIG_W-1:0] o_cos,
    output logic signed [uvs_pkg::TRIG_W-1:0] o_sin
);
    import uvs_pkg::*;

    localparam int N = TRIG_ITERATIONS;

    logic signed [CORDIC_W-1:0] r_x [N+1];
    logic signed [CORDIC_W-1:0] r_y [N+1];
    logic signed [CORDIC_W-1:0] r_z [N+1];
    logic [1:0]                 r_quad [N+1];
    t_tag                       r_tag [N+1];
    t_tag                       r_tag_out;
    logic signed [TRIG_W-1:0]   r_cos;
    logic signed [TRIG_W-1:0]   r_sin;
    logic [PHASE_W-1:0]         shifted;

    // Shift by an eighth turn, split into quadrant and residual angle.
    assign shifted = i_phase + 32'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad[0] <= shifted[31:30];
            r_z[0]    <= $signed({3'b000, shifted[29:0]}) - 33'sh2000_0000;
            r_x[0]    <= CORDIC_START;
            r_y[0]    <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else if (i_en) begin
            r_tag[0] <= i_tag;
        end
    end

    // Rotation-mode micro-rotations, one per stage.
    for (genvar k = 0; k < N; k++) begin : g_iter
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        logic signed [CORDIC_W-1:0] ang;

        assign dx  = r_y[k] >>> k;
        assign dy  = r_x[k] >>> k;
        assign ang = $signed({1'b0, ATAN_TURNS[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][CORDIC_W-1]) begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - ang;
                end else begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + ang;
                end
                r_quad[k+1] <= r_quad[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1] <= '0;
            end else if (i_en) begin
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    // Quadrant rotation by multiples of a quarter turn.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_quad[N])
                2'd0: begin
                    r_cos <= r_x[N][TRIG_W-1:0];
                    r_sin <= r_y[N][TRIG_W-1:0];
                end
                2'd1: begin
                    r_cos <= -r_y[N][TRIG_W-1:0];
                    r_sin <= r_x[N][TRIG_W-1:0];
                end
                2'd2: begin
                    r_cos <= -r_x[N][TRIG_W-1:0];
                    r_sin <= -r_y[N][TRIG_W-1:0];
                end
                default: begin
                    r_cos <= r_y[N][TRIG_W-1:0];
                    r_sin <= -r_x[N][TRIG_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_out <= '0;
        end else if (i_en) begin
            r_tag_out <= r_tag[N];
        end
    end

    assign o_tag = r_tag_out;
    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

/* src/uvs_back.sv */
module uvs_back #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_job_valid,
    input  uvs_pkg::t_job             i_job,
    output logic                      o_pop,
    input  logic [uvs_pkg::RAD_W-1:0] i_radius,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic signed [uvs_pkg::POS_W-1:0]  o_pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]  o_pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]  o_pos_z,
    output logic signed [uvs_pkg::NORM_W-1:0] o_norm_x,
    output logic signed [uvs_pkg::NORM_W-1:0] o_norm_y,
    output logic signed [uvs_pkg::NORM_W-1:0] o_norm_z,
    output logic                      o_range_error
);
    import uvs_pkg::*;

    logic               en;
    t_tag               job_tag;
    t_tag               lat_tag, lon_tag, lat_ctag, lon_ctag, c_tag;
    logic [QUO_W-1:0]   lat_quo, lon_quo;
    logic [PHASE_W-1:0] lat_phase, lon_phase;
    logic signed [TRIG_W-1:0] cl, sl, cn, sn;

    // The whole back pipeline advances whenever the output slot can move.
    assign en      = !o_out_valid || i_out_ready;
    assign o_pop   = en && i_job_valid;
    assign job_tag = '{valid: o_pop, err: i_job.err};

    uvs_divider u_lat_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_tag(job_tag),
        .i_num(i_job.lat_num), .i_div(i_job.ns), .o_tag(lat_tag), .o_quo(lat_quo)
    );

    uvs_divider u_lon_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_tag(job_tag),
        .i_num(i_job.lon_num), .i_div(i_job.nc), .o_tag(lon_tag), .o_quo(lon_quo)
    );

    // Latitude counts down from a quarter turn.
    assign lat_phase = 32'h4000_0000 - lat_quo[PHASE_W-1:0];
    assign lon_phase = lon_quo[PHASE_W-1:0];

    uvs_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lat_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_tag(lat_tag),
        .i_phase(lat_phase), .o_tag(lat_ctag), .o_cos(cl), .o_sin(sl)
    );

    uvs_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lon_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_tag(lon_tag),
        .i_phase(lon_phase), .o_tag(lon_ctag), .o_cos(cn), .o_sin(sn)
    );

    assign c_tag = '{valid: lat_ctag.valid & lon_ctag.valid,
                     err:   lat_ctag.err | lon_ctag.err};

    // Stage M1: trig products and radius times sine of latitude.
    logic signed [63:0] r_pxy, r_pyy;
    logic signed [48:0] r_pz;
    logic signed [TRIG_W-1:0] r_sl;
    t_tag r_tag_m1, r_tag_m2, r_tag_m3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxy <= 64'(cl) * 64'(cn);
            r_pyy <= 64'(cl) * 64'(sn);
            r_pz  <= 49'($signed({1'b0, i_radius})) * 49'(sl);
            r_sl  <= sl;
        end
    end

    // Stage M2: rounded products, normals and z position.
    logic signed [63:0] rx_full, ry_full, nx_full, ny_full, nz_full;
    logic signed [48:0] pz_full;
    logic signed [33:0] r_rx, r_ry;
    logic signed [NORM_W-1:0] r_nx, r_ny, r_nz;
    logic signed [POS_W-1:0]  r_pz_m2;

    always_comb begin
        rx_full = (r_pxy + (64'sd1 <<< 29)) >>> 30;
        ry_full = (r_pyy + (64'sd1 <<< 29)) >>> 30;
        nx_full = (r_pxy + (64'sd1 <<< 45)) >>> 46;
        ny_full = (r_pyy + (64'sd1 <<< 45)) >>> 46;
        nz_full = (64'(r_sl) + (64'sd1 <<< 15)) >>> 16;
        pz_full = (r_pz + (49'sd1 <<< 29)) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx    <= rx_full[33:0];
            r_ry    <= ry_full[33:0];
            r_nx    <= NORM_W'(clamp_sym(nx_full, 64'(NORM_LIMIT)));
            r_ny    <= NORM_W'(clamp_sym(ny_full, 64'(NORM_LIMIT)));
            r_nz    <= NORM_W'(clamp_sym(nz_full, 64'(NORM_LIMIT)));
            r_pz_m2 <= POS_W'(clamp_sym(64'(pz_full), 64'(POS_LIMIT)));
        end
    end

    // Stage M3: scale the horizontal products by the radius.
    logic signed [50:0] r_mx, r_my;
    logic signed [NORM_W-1:0] r_nx_m3, r_ny_m3, r_nz_m3;
    logic signed [POS_W-1:0]  r_pz_m3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx    <= 51'($signed({1'b0, i_radius})) * 51'(r_rx);
            r_my    <= 51'($signed({1'b0, i_radius})) * 51'(r_ry);
            r_nx_m3 <= r_nx;
            r_ny_m3 <= r_ny;
            r_nz_m3 <= r_nz;
            r_pz_m3 <= r_pz_m2;
        end
    end

    // Output stage: round, saturate, and zero the result on a range error.
    logic signed [50:0] px_full, py_full;
    logic               r_out_valid;
    logic signed [POS_W-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic signed [NORM_W-1:0] r_norm_x, r_norm_y, r_norm_z;
    logic               r_err;

    always_comb begin
        px_full = (r_mx + (51'sd1 <<< 29)) >>> 30;
        py_full = (r_my + (51'sd1 <<< 29)) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_err <= r_tag_m3.err;
            if (r_tag_m3.err) begin
                r_pos_x  <= '0;
                r_pos_y  <= '0;
                r_pos_z  <= '0;
                r_norm_x <= '0;
                r_norm_y <= '0;
                r_norm_z <= '0;
            end else begin
                r_pos_x  <= POS_W'(clamp_sym(64'(px_full), 64'(POS_LIMIT)));
                r_pos_y  <= POS_W'(clamp_sym(64'(py_full), 64'(POS_LIMIT)));
                r_pos_z  <= r_pz_m3;
                r_norm_x <= r_nx_m3;
                r_norm_y <= r_ny_m3;
                r_norm_z <= r_nz_m3;
            end
        end
    end

    // Tag pipeline beside the arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_m1    <= '0;
            r_tag_m2    <= '0;
            r_tag_m3    <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_tag_m1    <= c_tag;
            r_tag_m2    <= r_tag_m1;
            r_tag_m3    <= r_tag_m2;
            r_out_valid <= r_tag_m3.valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_pos_z       = r_pos_z;
    assign o_norm_x      = r_norm_x;
    assign o_norm_y      = r_norm_y;
    assign o_norm_z      = r_norm_z;
    assign o_range_error = r_err;

endmodule

/* src/uv_sphere_vertex_generator.sv */
// UV sphere vertex generator.
// Input channel (i_in_valid / o_in_ready) takes one grid point per transaction:
// a stack index and a sector index. Output channel (o_out_valid / i_out_ready)
// returns one transaction per input, in order: the vertex position in Q4.12,
// the unit normal in Q1.14 and a range error flag that zeroes the vector fields.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); write it
// only while no transaction is in flight.
// The transaction is written into the two-entry job queue at the accepting edge,
// then passes through the bit-per-stage dividers that form the angle phases, the
// pipelined CORDIC units and the multiply and rounding stages before o_out_valid.
// Throughput is one transaction per cycle while the receiver keeps ready high.
// When the receiver stalls, the whole back pipeline holds; the queue then takes
// up to two more transactions before o_in_ready drops.
// Synchronous reset empties the queue and pipeline and restores the counts to
// 150 and the radius to 1.0.
`include "uv_sphere_vertex_generator_defines.svh"

module uv_sphere_vertex_generator #(
    parameter int MAX_DIVISIONS   = 1024,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [uvs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [uvs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [uvs_pkg::IDX_W-1:0]     i_stack_index,
    input  logic [uvs_pkg::IDX_W-1:0]     i_sector_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [uvs_pkg::POS_W-1:0]  o_pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]  o_pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]  o_pos_z,
    output logic signed [uvs_pkg::NORM_W-1:0] o_norm_x,
    output logic signed [uvs_pkg::NORM_W-1:0] o_norm_y,
    output logic signed [uvs_pkg::NORM_W-1:0] o_norm_z,
    output logic                          o_range_error
);
    import uvs_pkg::*;

    logic [CNT_W-1:0] r_stack_count;
    logic [CNT_W-1:0] r_sector_count;
    logic [RAD_W-1:0] r_sphere_radius;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count   <= CNT_W'(150);
            r_sector_count  <= CNT_W'(150);
            r_sphere_radius <= RAD_W'(4096);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_STACK_COUNT:   r_stack_count   <= i_cfg_data[CNT_W-1:0];
                CFG_SECTOR_COUNT:  r_sector_count  <= i_cfg_data[CNT_W-1:0];
                CFG_SPHERE_RADIUS: r_sphere_radius <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    logic push, pop, fifo_full, fifo_empty;
    t_job front_job, queue_job;

    assign o_in_ready = !fifo_full;

    uvs_front #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_front (
        .i_valid(i_in_valid && o_in_ready),
        .i_stack_index(i_stack_index),
        .i_sector_index(i_sector_index),
        .i_stack_count(r_stack_count),
        .i_sector_count(r_sector_count),
        .o_push(push),
        .o_job(front_job)
    );

    uvs_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(front_job),
        .i_pop(pop), .o_data(queue_job),
        .o_full(fifo_full), .o_empty(fifo_empty)
    );

    uvs_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(!fifo_empty), .i_job(queue_job), .o_pop(pop),
        .i_radius(r_sphere_radius),
        .i_out_ready(i_out_ready), .o_out_valid(o_out_valid),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_norm_x(o_norm_x), .o_norm_y(o_norm_y), .o_norm_z(o_norm_z),
        .o_range_error(o_range_error)
    );

    // An error result carries an all-zero vector.
    `UVS_ASSERT_IMPLIES(a_err_zero, i_clk, i_rst_n, o_out_valid && o_range_error,
        o_pos_x == '0 && o_pos_y == '0 && o_pos_z == '0 &&
        o_norm_x == '0 && o_norm_y == '0 && o_norm_z == '0)

    // The x and z normals never leave the unit range.
    `UVS_ASSERT_IMPLIES(a_norm_range, i_clk, i_rst_n, o_out_valid,
        o_norm_x <= 16'sd16384 && o_norm_x >= -16'sd16384 &&
        o_norm_z <= 16'sd16384 && o_norm_z >= -16'sd16384)

    // Positions saturate symmetrically.
    `UVS_ASSERT_IMPLIES(a_pos_range, i_clk, i_rst_n, o_out_valid,
        o_pos_x != -17'sd65536 && o_pos_y != -17'sd65536 && o_pos_z != -17'sd65536)

    // A transaction that is not consumed at once stays queued.
    `UVS_ASSERT_NEXT(a_queue_holds, i_clk, i_rst_n, push && !pop, !fifo_empty)

endmodule
